FILE: hdl/sst_pkg.sv
// Shared types and constants for the sorted set table.
// Used by sst_cell and sorted_set_table; depends on nothing else.
package sst_pkg;

  // Operation codes carried in the input transfer.
  localparam logic [1:0] OP_MEMBER = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Cells per group in the registered match reduction.
  localparam int unsigned GROUP_SIZE = 16;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic       success;
    logic       full_reject;
    logic [8:0] entries_held;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        cmp;
    logic        ins;
    logic        del;
    logic [15:0] key;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

endpackage

FILE: hdl/sst_cell.sv
// One cell of the sorted chain: a stored value, its valid bit and the
// registered less-than flag. Depends on sst_pkg.
module sst_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sst_pkg::cell_ctl_t    ctl,
  input  logic [15:0]           left_value,
  input  logic                  left_valid,
  input  logic                  left_lt,
  input  logic [15:0]           right_value,
  input  logic                  right_valid,
  output logic [15:0]           value,
  output logic                  valid,
  output logic                  lt,
  output logic                  eq
);

  logic [15:0] value_r;
  logic [15:0] value_nxt;
  logic        valid_r;
  logic        valid_nxt;
  logic        lt_r;

  // Compare the held value against the broadcast key.
  assign eq = valid_r && (value_r == ctl.key);

  // Cells below the key stay; the rest shift up on insert, down on delete.
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.ins && !lt_r) begin
      if (left_lt) begin
        value_nxt = ctl.key;
        valid_nxt = 1'b1;
      end else begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end
    end else if (ctl.del && !lt_r) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.cmp) begin
        lt_r <= valid_r && (value_r < ctl.key);
      end
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;
  assign lt    = lt_r;

endmodule

FILE: hdl/sorted_set_table.sv
// Top level of the sorted set table: controller, cell chain, match
// reduction and result register. Depends on sst_pkg and sst_cell.
//
//   Channel  Direction  Payload               Handshake
//   in_      input      sst_pkg::in_item_t    in_valid / in_stall
//   out_     output     sst_pkg::out_item_t   out_valid / out_stall
//
// An item passes the transfer, a compare state in which every cell checks the
// key and groups of 16 match flags are registered, and an apply state that
// reduces the group flags and shifts the chain on a successful insert or delete.
// A new item is taken once the previous one has reached the result register.
// Reset (rst_n low, synchronous) empties the table at once; no sweep is needed.
// A stalled result holds the apply cycle until the result register is free.
module sorted_set_table #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sst_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sst_pkg::out_item_t  out_item
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned NGRP = (CAPACITY + sst_pkg::GROUP_SIZE - 1) / sst_pkg::GROUP_SIZE;

  sst_pkg::state_t    state_r;
  sst_pkg::state_t    state_nxt;
  logic [1:0]         op_r;
  logic [15:0]        key_r;
  logic [CW-1:0]      occ_r;
  logic [CW-1:0]      occ_nxt;
  logic [NGRP-1:0]    grp_hit_r;
  logic [NGRP-1:0]    grp_hit_nxt;
  logic [NGRP*sst_pkg::GROUP_SIZE-1:0] eq_pad;
  logic               out_valid_r;
  sst_pkg::out_item_t out_item_r;
  sst_pkg::out_item_t res;
  sst_pkg::cell_ctl_t ctl;
  logic               apply_go;
  logic               found;
  logic               is_full;
  logic [CW+8:0]      occ_ext;

  logic [15:0] cell_value [CAPACITY];
  logic        cell_valid [CAPACITY];
  logic        cell_lt    [CAPACITY];
  logic [CAPACITY-1:0] cell_eq;

  // Cell chain: each cell sees its left and right neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [15:0] lv;
    logic        lvd;
    logic        llt;
    logic [15:0] rv;
    logic        rvd;
    if (i == 0) begin : g_first
      assign lv  = key_r;
      assign lvd = 1'b0;
      assign llt = 1'b1;
    end else begin : g_mid
      assign lv  = cell_value[i-1];
      assign lvd = cell_valid[i-1];
      assign llt = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv  = key_r;
      assign rvd = 1'b0;
    end else begin : g_inner
      assign rv  = cell_value[i+1];
      assign rvd = cell_valid[i+1];
    end
    sst_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_value  (lv),
      .left_valid  (lvd),
      .left_lt     (llt),
      .right_value (rv),
      .right_valid (rvd),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i])
    );
  end

  // First level of the match reduction: one flag per group of cells.
  always_comb begin
    eq_pad = '0;
    eq_pad[CAPACITY-1:0] = cell_eq;
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g] = |eq_pad[g*sst_pkg::GROUP_SIZE +: sst_pkg::GROUP_SIZE];
    end
  end

  assign found    = |grp_hit_r;
  assign is_full  = (occ_r == CW'(CAPACITY));
  assign apply_go = (state_r == sst_pkg::ST_APPLY) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sst_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sst_pkg::ST_CMP;
        end
      end
      sst_pkg::ST_CMP: begin
        state_nxt = sst_pkg::ST_APPLY;
      end
      sst_pkg::ST_APPLY: begin
        if (apply_go) begin
          state_nxt = sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sst_pkg::ST_IDLE;
      end
    endcase
  end

  // Controller outputs: cell broadcast, count update and result.
  always_comb begin
    ctl     = '0;
    ctl.key = key_r;
    occ_nxt = occ_r;
    res     = '0;
    case (state_r)
      sst_pkg::ST_CMP: begin
        ctl.cmp = 1'b1;
      end
      sst_pkg::ST_APPLY: begin
        case (op_r)
          sst_pkg::OP_MEMBER: begin
            res.success = found;
          end
          sst_pkg::OP_INSERT: begin
            res.success     = !found && !is_full;
            res.full_reject = !found && is_full;
            if (apply_go && !found && !is_full) begin
              ctl.ins = 1'b1;
              occ_nxt = occ_r + CW'(1);
            end
          end
          sst_pkg::OP_DELETE: begin
            res.success = found;
            if (apply_go && found) begin
              ctl.del = 1'b1;
              occ_nxt = occ_r - CW'(1);
            end
          end
          default: begin
            res.success = 1'b0;
          end
        endcase
      end
      default: begin
        ctl.cmp = 1'b0;
      end
    endcase
    occ_ext          = (CW + 9)'(occ_nxt);
    res.entries_held = occ_ext[8:0];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sst_pkg::ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == sst_pkg::ST_IDLE && in_valid) begin
      op_r  <= in_item.operation;
      key_r <= in_item.key_value;
    end
    if (state_r == sst_pkg::ST_CMP) begin
      grp_hit_r <= grp_hit_nxt;
    end
    if (apply_go) begin
      out_item_r <= res;
    end
  end

  assign in_stall  = (state_r != sst_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The count never passes the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  // The head cell holds a value exactly when the table is not empty.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[0] == (occ_r != '0))
    else $error("head cell valid disagrees with occupancy");

  // A new result appears only right after an apply cycle.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == sst_pkg::ST_APPLY))
    else $error("result without apply cycle");

endmodule
